@@ sv/mcoc_pkg.sv @@
// Shared types, constants and helpers for the matrix chain order cost block.
// Used by every module of the block; depends on nothing.
package mcoc_pkg;

  localparam int COST_W     = 34;
  localparam int IN_DIM_W   = 10;
  localparam int CMD_DIM_W  = 16;
  localparam int CMD_CNT_W  = 7;
  localparam int PROD_W     = 48;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_TOO_FEW  = 2'd1;
  localparam status_t STATUS_TOO_MANY = 2'd2;

  typedef struct packed {
    logic [IN_DIM_W-1:0] dim;
    logic                last;
  } item_t;

  typedef struct packed {
    logic [COST_W-1:0] min_cost;
    status_t           status;
  } result_t;

  typedef struct packed {
    logic                 wr;
    logic                 go;
    logic [CMD_CNT_W-1:0] idx;
    logic [CMD_DIM_W-1:0] dim;
    logic [CMD_CNT_W-1:0] count;
    status_t              status;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MULQ,
    ST_RUN,
    ST_DRAIN,
    ST_WRITE,
    ST_RESULT
  } state_t;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

endpackage

@@ sv/matrix_chain_order_cost_top.sv @@
// Flow: an item without last is queued as a store command while the chain has room;
// after the last item the solver runs every interval in turn, then the result
// is shown.
// Throughput: set by the single-split-per-cycle cost pipeline; input stalls
// once the two-entry command queue fills behind a running solve.
// Reset (rst, synchronous): clears counters, queue and result valid flag; no memory pass.
module matrix_chain_order_cost_top #(
  parameter int MAX_MATRICES = 16,
  parameter int DIM_BITS     = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  mcoc_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output mcoc_pkg::result_t result
);
  import mcoc_pkg::*;

  cmd_t f_cmd;
  cmd_t b_cmd;
  logic f_push;
  logic q_full;
  logic q_valid;
  logic b_pop;

  mcoc_front #(
    .MAX_MATRICES(MAX_MATRICES),
    .DIM_BITS    (DIM_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .cmd_push(f_push),
    .cmd     (f_cmd),
    .cmd_full(q_full)
  );

  mcoc_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (f_push),
    .wr_data(f_cmd),
    .full   (q_full),
    .rd_en  (b_pop),
    .rd_data(b_cmd),
    .valid  (q_valid)
  );

  mcoc_back #(
    .MAX_MATRICES(MAX_MATRICES),
    .DIM_BITS    (DIM_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(q_valid),
    .cmd      (b_cmd),
    .cmd_pop  (b_pop),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

@@ sv/mcoc_front.sv @@
// Front end: accepts dimension items, tracks chain length and overflow,
// and turns each item that fits, and the last, into a store and/or solve command. Uses mcoc_pkg.
module mcoc_front #(
  parameter int MAX_MATRICES = 16,
  parameter int DIM_BITS     = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  mcoc_pkg::item_t item,
  output logic          cmd_push,
  output mcoc_pkg::cmd_t cmd,
  input  logic          cmd_full
);
  import mcoc_pkg::*;

  localparam int CNT_W = $clog2(MAX_MATRICES + 2);

  logic [CNT_W-1:0]    cnt;
  logic                ovf;
  logic                accept;
  logic                stored;
  logic [CNT_W-1:0]    cnt_after;
  logic [DIM_BITS-1:0] dim_m;

  assign full      = cmd_full;
  assign accept    = push && !full;
  assign stored    = cnt < CNT_W'(MAX_MATRICES + 1);
  assign cnt_after = stored ? cnt + CNT_W'(1) : cnt;
  assign dim_m     = DIM_BITS'(item.dim);
  assign cmd_push  = accept && (stored || item.last);

  always_comb begin
    cmd.wr    = stored;
    cmd.go    = item.last;
    cmd.idx   = CMD_CNT_W'(cnt);
    cmd.dim   = CMD_DIM_W'(dim_m);
    cmd.count = CMD_CNT_W'(cnt_after);
    priority if (cnt_after < CNT_W'(2)) begin
      cmd.status = STATUS_TOO_FEW;
    end else if (ovf || !stored) begin
      cmd.status = STATUS_TOO_MANY;
    end else begin
      cmd.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (accept) begin
      if (item.last) begin
        cnt <= '0;
        ovf <= 1'b0;
      end else begin
        cnt <= cnt_after;
        ovf <= ovf || !stored;
      end
    end
  end

endmodule

@@ sv/mcoc_fifo.sv @@
// Two-entry command queue between front end and solver.
// Uses mcoc_pkg for the command type.
module mcoc_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  mcoc_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output mcoc_pkg::cmd_t rd_data,
  output logic           valid
);
  import mcoc_pkg::*;

  cmd_t                  slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp;
  logic [FIFO_PTR_W-1:0] rp;
  logic [FIFO_CNT_W-1:0] cnt;
  logic                  do_wr;
  logic                  do_rd;

  assign full    = cnt == FIFO_CNT_W'(FIFO_DEPTH);
  assign valid   = cnt != '0;
  assign rd_data = slots[rp];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) begin
        wp <= wp + FIFO_PTR_W'(1);
      end
      if (do_rd) begin
        rp <= rp + FIFO_PTR_W'(1);
      end
      cnt <= cnt + FIFO_CNT_W'(do_wr) - FIFO_CNT_W'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wp] <= wr_data;
    end
  end

endmodule

@@ sv/mcoc_back.sv @@
// Solver: stores dimensions, fills the interval cost table one split per
// cycle through a three-stage pipeline, and holds the result register.
// Uses mcoc_pkg.
module mcoc_back #(
  parameter int MAX_MATRICES = 16,
  parameter int DIM_BITS     = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  mcoc_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  output mcoc_pkg::result_t result,
  output logic              empty,
  input  logic              pop
);
  import mcoc_pkg::*;

  localparam int IDX_W      = $clog2(MAX_MATRICES);
  localparam int LEN_W      = $clog2(MAX_MATRICES + 1);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int DIM_DEPTH  = MAX_MATRICES + 1;
  localparam int COST_DEPTH = 1 << ADDR_W;
  localparam int Q_W        = 2 * DIM_BITS;
  localparam int P_W        = 3 * DIM_BITS;

  state_t state;
  state_t state_next;

  logic [DIM_BITS-1:0] dim_mem  [DIM_DEPTH];
  logic [COST_W-1:0]   cost_mem [COST_DEPTH];

  logic [DIM_BITS-1:0] rd_a;
  logic [DIM_BITS-1:0] rd_b;
  logic [COST_W-1:0]   rd_l;
  logic [COST_W-1:0]   rd_r;

  logic [IDX_W-1:0]  i;
  logic [IDX_W-1:0]  k;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  mats;
  status_t           status_r;
  logic [COST_W-1:0] res_cost;
  logic [Q_W-1:0]    q;
  logic [COST_W-1:0] best;
  logic              v1;
  logic              zl1;
  logic              zr1;
  logic              v2;
  logic [COST_W-1:0] s2;
  logic [COST_W-1:0] p2;
  logic              out_valid;
  result_t           out_data;

  logic [LEN_W-1:0]  j_ext;
  logic [IDX_W-1:0]  j;
  logic [IDX_W-1:0]  k1;
  logic [LEN_W-1:0]  dim_raddr_a;
  logic [LEN_W-1:0]  dim_raddr_b;
  logic              dim_we;
  logic              issue;
  logic              cost_we;
  logic              load_out;
  logic              last_issue;
  logic              last_in_len;
  logic              final_iv;
  logic              short_chain;
  logic [P_W-1:0]    prod;
  logic [PROD_W-1:0] prod_ext;
  logic [COST_W-1:0] prod_sat;
  logic [COST_W-1:0] step_cost;

  assign j_ext       = LEN_W'(i) + len - LEN_W'(1);
  assign j           = IDX_W'(j_ext);
  assign k1          = k + IDX_W'(1);
  assign last_issue  = k1 == j;
  assign last_in_len = j_ext == mats - LEN_W'(1);
  assign final_iv    = last_in_len && (len == mats);
  assign short_chain = (cmd.status == STATUS_TOO_FEW) || (cmd.count == CMD_CNT_W'(2));

  assign prod      = q * rd_b;
  assign prod_ext  = PROD_W'(prod);
  assign prod_sat  = (prod_ext > PROD_W'(COST_MAX)) ? COST_MAX : prod_ext[COST_W-1:0];
  assign step_cost = sat_add(s2, p2);

  assign result = out_data;
  assign empty  = !out_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && cmd.go) begin
          state_next = short_chain ? ST_RESULT : ST_SETUP;
        end
      end
      ST_SETUP: state_next = ST_MULQ;
      ST_MULQ:  state_next = ST_RUN;
      ST_RUN: begin
        if (last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1 && !v2) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: state_next = final_iv ? ST_RESULT : ST_SETUP;
      ST_RESULT: begin
        if (!out_valid || pop) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop     = (state == ST_IDLE) && cmd_valid;
    dim_we      = cmd_pop && cmd.wr;
    issue       = state == ST_RUN;
    cost_we     = state == ST_WRITE;
    load_out    = (state == ST_RESULT) && (!out_valid || pop);
    dim_raddr_a = LEN_W'(i);
    dim_raddr_b = (state == ST_SETUP) ? j_ext + LEN_W'(1) : LEN_W'(k) + LEN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (dim_we) begin
      dim_mem[LEN_W'(cmd.idx)] <= cmd.dim[DIM_BITS-1:0];
    end
    rd_a <= dim_mem[dim_raddr_a];
    rd_b <= dim_mem[dim_raddr_b];
  end

  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[{i, j}] <= best;
    end
    rd_l <= cost_mem[{i, k}];
    rd_r <= cost_mem[{k1, j}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issue;
      v2    <= v1;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.go) begin
      len      <= LEN_W'(2);
      i        <= '0;
      mats     <= LEN_W'(cmd.count - CMD_CNT_W'(1));
      status_r <= cmd.status;
      res_cost <= '0;
    end
    if (state == ST_MULQ) begin
      q <= rd_a * rd_b;
      k <= i;
    end else if (issue) begin
      k <= k1;
    end
    if (issue) begin
      zl1 <= k == i;
      zr1 <= last_issue;
    end
    s2 <= sat_add(zl1 ? '0 : rd_l, zr1 ? '0 : rd_r);
    p2 <= prod_sat;
    if (state == ST_MULQ) begin
      best <= COST_MAX;
    end else if (v2 && (step_cost < best)) begin
      best <= step_cost;
    end
    if (cost_we) begin
      if (final_iv) begin
        res_cost <= best;
      end else if (last_in_len) begin
        len <= len + LEN_W'(1);
        i   <= '0;
      end else begin
        i <= i + IDX_W'(1);
      end
    end
    if (load_out) begin
      out_data.min_cost <= res_cost;
      out_data.status   <= status_r;
    end
  end

  a_split_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> k < j)
    else $error("split point past interval end");

  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(v1))
    else $error("stage two valid without stage one");

  a_write_drained: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRITE |-> !v1 && !v2)
    else $error("table write before pipeline drained");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(out_data))
    else $error("waiting result overwritten");

endmodule
